// ----- rtl/depth_gradient_3x3_unit_assert.svh -----
// assertion macros shared by the depth gradient rtl
// expects signals named clock and reset in the including module
`ifndef DEPTH_GRADIENT_3X3_UNIT_ASSERT_SVH
`define DEPTH_GRADIENT_3X3_UNIT_ASSERT_SVH

// same-cycle implication
`define DGRAD_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DGRAD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/dgrad_pkg.sv -----
// shared types and constants of the depth gradient unit
// no dependencies
package dgrad_pkg;

   localparam int MAX_WIDTH_DEF  = 128;
   localparam int PIXEL_BITS_DEF = 16;
   localparam int OUT_DEPTH_DEF  = 8;

   localparam int REQ_DATA_W   = 16;
   localparam int GRAD_W       = 19;
   localparam int RSP_DATA_W   = 40;
   localparam int WIDTH_REG_W  = 8;
   localparam int HEIGHT_REG_W = 13;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 8'd80;
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd60;

   typedef enum logic [0:0] {
      REG_IMAGE_WIDTH  = 1'b0,
      REG_IMAGE_HEIGHT = 1'b1
   } dgrad_reg_type;

   // per-request control that travels down the pipeline
   typedef struct packed {
      logic valid;
      logic result;
      logic has_w;
      logic has_n;
      logic last;
   } dgrad_tag_type;

endpackage

// ----- rtl/dgrad_line_buf.sv -----
// two-row line buffer held in one synchronous memory, read-modify-write per pixel
// depends on dgrad_pkg
module dgrad_line_buf #(
   parameter int MAX_WIDTH  = dgrad_pkg::MAX_WIDTH_DEF,
   parameter int PIXEL_BITS = dgrad_pkg::PIXEL_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  rd_en,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]        rd_addr,
   input  logic [PIXEL_BITS-1:0]                 px_i,
   input  dgrad_pkg::dgrad_tag_type              tag_i,
   output dgrad_pkg::dgrad_tag_type              tag_o,
   output logic [PIXEL_BITS-1:0]                 px_o,
   output logic [PIXEL_BITS-1:0]                 above_o,
   output logic [PIXEL_BITS-1:0]                 two_above_o
);
   localparam int DEPTH  = MAX_WIDTH + 1;
   localparam int ADDR_W = $clog2(DEPTH);

   // low half: row above, high half: row two above
   logic [2*PIXEL_BITS-1:0] mem [DEPTH];
   logic [2*PIXEL_BITS-1:0] rdata_ff;
   logic [ADDR_W-1:0]       addr_ff;
   logic [PIXEL_BITS-1:0]   px_ff;
   dgrad_pkg::dgrad_tag_type tag_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
      // shift the column down one row: old above becomes two above
      if (tag_ff.valid) begin
         mem[addr_ff] <= {rdata_ff[PIXEL_BITS-1:0], px_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else begin
         tag_ff <= rd_en ? tag_i : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         addr_ff <= rd_addr;
         px_ff   <= px_i;
      end
   end

   assign tag_o       = tag_ff;
   assign px_o        = px_ff;
   assign above_o     = rdata_ff[PIXEL_BITS-1:0];
   assign two_above_o = rdata_ff[2*PIXEL_BITS-1:PIXEL_BITS];

endmodule

// ----- rtl/dgrad_window.sv -----
// 3x3 window registers, masked pair differences and gradient sums
// depends on dgrad_pkg
module dgrad_window #(
   parameter int PIXEL_BITS = dgrad_pkg::PIXEL_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  dgrad_pkg::dgrad_tag_type             tag_i,
   input  logic [PIXEL_BITS-1:0]                px_i,
   input  logic [PIXEL_BITS-1:0]                above_i,
   input  logic [PIXEL_BITS-1:0]                two_above_i,
   output logic                                 push_o,
   output logic signed [dgrad_pkg::GRAD_W-1:0]  grad_x_o,
   output logic signed [dgrad_pkg::GRAD_W-1:0]  grad_y_o,
   output logic                                 last_o
);
   localparam int GW = dgrad_pkg::GRAD_W;

   // row 0 two above, row 1 above, row 2 current; column 0 oldest
   logic [PIXEL_BITS-1:0]       win_ff [3][3];
   dgrad_pkg::dgrad_tag_type    tag2_ff;
   dgrad_pkg::dgrad_tag_type    tag3_ff;
   logic signed [PIXEL_BITS:0]  diff_ff [4];
   logic signed [PIXEL_BITS:0]  diff_in [4];

   function automatic logic signed [PIXEL_BITS:0] pair_diff(
      input logic [PIXEL_BITS-1:0] far_v,
      input logic [PIXEL_BITS-1:0] near_v,
      input logic                  ok
   );
      logic signed [PIXEL_BITS:0] res;
      res = '0;
      if (ok && far_v != '0 && near_v != '0) begin
         res = $signed({1'b0, far_v}) - $signed({1'b0, near_v});
      end
      return res;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               win_ff[i][j] <= '0;
            end
         end
      end else if (tag_i.valid) begin
         for (int i = 0; i < 3; i++) begin
            win_ff[i][0] <= win_ff[i][1];
            win_ff[i][1] <= win_ff[i][2];
         end
         win_ff[0][2] <= two_above_i;
         win_ff[1][2] <= above_i;
         win_ff[2][2] <= px_i;
      end
   end

   always_comb begin
      diff_in[0] = pair_diff(win_ff[1][2], win_ff[1][0], tag2_ff.has_w);
      diff_in[1] = pair_diff(win_ff[0][2], win_ff[2][0], tag2_ff.has_w && tag2_ff.has_n);
      diff_in[2] = pair_diff(win_ff[0][1], win_ff[2][1], tag2_ff.has_n);
      diff_in[3] = pair_diff(win_ff[0][0], win_ff[2][2], tag2_ff.has_w && tag2_ff.has_n);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag2_ff <= '0;
         tag3_ff <= '0;
      end else begin
         tag2_ff <= tag_i;
         tag3_ff <= tag2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (tag2_ff.valid) begin
         for (int k = 0; k < 4; k++) begin
            diff_ff[k] <= diff_in[k];
         end
      end
   end

   assign push_o   = tag3_ff.valid && tag3_ff.result;
   assign last_o   = tag3_ff.last;
   assign grad_x_o = GW'(diff_ff[0]) + GW'(diff_ff[1]) - GW'(diff_ff[3]);
   assign grad_y_o = GW'(diff_ff[1]) + GW'(diff_ff[2]) + GW'(diff_ff[3]);

endmodule

// ----- rtl/dgrad_out_fifo.sv -----
// result queue between the gradient pipeline and the response channel
// depends on dgrad_pkg
module dgrad_out_fifo #(
   parameter int OUT_DEPTH = dgrad_pkg::OUT_DEPTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 push,
   input  logic signed [dgrad_pkg::GRAD_W-1:0]  grad_x_i,
   input  logic signed [dgrad_pkg::GRAD_W-1:0]  grad_y_i,
   input  logic                                 last_i,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [dgrad_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                 rsp_tlast
);
   localparam int GW      = dgrad_pkg::GRAD_W;
   localparam int ENTRY_W = 2 * GW + 1;
   localparam int PTR_W   = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
   localparam int COUNT_W = $clog2(OUT_DEPTH + 1);

   logic [ENTRY_W-1:0] store_ff [OUT_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               pop;
   logic [ENTRY_W-1:0] head;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(OUT_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign pop = rsp_tvalid && rsp_tready;

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= {last_i, grad_y_i, grad_x_i};
      end
   end

   assign head       = store_ff[rd_ptr_ff];
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tlast  = head[ENTRY_W-1];
   assign rsp_tdata  = dgrad_pkg::RSP_DATA_W'(head[2*GW-1:0]);

endmodule

// ----- rtl/depth_gradient_3x3_unit.sv -----
// a result passes the line buffer, window and difference registers and queue to rsp
// throughput: one request per clock while a queue slot is free; the line buffer memory
//    is read and written back once per pixel, the window and queue keep pace with no stall
// reset clears counters, pipeline and queue; image_width returns to 80, image_height to 60
// the line buffer is not cleared: entries outside the frame are masked by position
// a result needs a free queue slot reserved at accept time (OUT_DEPTH slots)
module depth_gradient_3x3_unit #(
   parameter int MAX_WIDTH  = dgrad_pkg::MAX_WIDTH_DEF,
   parameter int PIXEL_BITS = dgrad_pkg::PIXEL_BITS_DEF,
   parameter int OUT_DEPTH  = dgrad_pkg::OUT_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [dgrad_pkg::REQ_DATA_W-1:0]    req_tdata,   // [15:0] depth
   // response channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [dgrad_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // [18:0] grad_x, [37:19] grad_y, zeros
   output logic                                rsp_tlast,   // frame_last
   // register port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [dgrad_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [dgrad_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [dgrad_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                csr_pready
);
   localparam int COL_W   = $clog2(MAX_WIDTH + 1);
   localparam int ROW_W   = dgrad_pkg::HEIGHT_REG_W;
   localparam int WREG_W  = dgrad_pkg::WIDTH_REG_W;
   localparam int CMP_W   = (COL_W > WREG_W) ? COL_W : WREG_W;
   localparam int COUNT_W = $clog2(OUT_DEPTH + 1);

   // configuration registers
   logic [WREG_W-1:0] width_ff, width_in;
   logic [ROW_W-1:0]  height_ff, height_in;
   logic              csr_wr;
   dgrad_pkg::dgrad_reg_type csr_reg;

   // stream position of the next request
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] eff_w;
   logic [ROW_W-1:0] eff_h;
   logic [CMP_W-1:0] width_ext;

   // queue slot reservation
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic               req_acc, rsp_acc;

   logic [PIXEL_BITS-1:0]    px;
   dgrad_pkg::dgrad_tag_type tag0;
   dgrad_pkg::dgrad_tag_type tag1;
   logic [PIXEL_BITS-1:0]    px1, above1, two_above1;
   logic                     push;
   logic signed [dgrad_pkg::GRAD_W-1:0] grad_x, grad_y;
   logic                     last;

   // register port: always ready
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_reg    = dgrad_pkg::dgrad_reg_type'(csr_paddr[2]);

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_wr) begin
         unique case (csr_reg)
            dgrad_pkg::REG_IMAGE_WIDTH:  width_in  = csr_pwdata[WREG_W-1:0];
            dgrad_pkg::REG_IMAGE_HEIGHT: height_in = csr_pwdata[ROW_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_reg)
         dgrad_pkg::REG_IMAGE_WIDTH:  csr_prdata = dgrad_pkg::CSR_DATA_W'(width_ff);
         dgrad_pkg::REG_IMAGE_HEIGHT: csr_prdata = dgrad_pkg::CSR_DATA_W'(height_ff);
         default:                     csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= dgrad_pkg::WIDTH_RESET;
         height_ff <= dgrad_pkg::HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // effective frame size: width clamped to 1..MAX_WIDTH, height at least 1
   assign width_ext = CMP_W'(width_ff);
   always_comb begin
      if (width_ff == '0) begin
         eff_w = COL_W'(1);
      end else if (width_ext > CMP_W'(MAX_WIDTH)) begin
         eff_w = COL_W'(MAX_WIDTH);
      end else begin
         eff_w = COL_W'(width_ext);
      end
      eff_h = (height_ff == '0) ? ROW_W'(1) : height_ff;
   end

   assign req_acc = req_tvalid && req_tready;
   assign rsp_acc = rsp_tvalid && rsp_tready;

   // padding column and padding row pixels count as zero
   assign px = (col_ff == eff_w || row_ff == eff_h) ? '0 : req_tdata[PIXEL_BITS-1:0];

   always_comb begin
      tag0.valid  = 1'b1;
      tag0.result = (col_ff != '0) && (row_ff != '0);
      tag0.has_w  = (col_ff > COL_W'(1));
      tag0.has_n  = (row_ff > ROW_W'(1));
      tag0.last   = (col_ff == eff_w) && (row_ff == eff_h);
   end

   // raster position; a register write restarts the frame
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (csr_wr) begin
         col_in = '0;
         row_in = '0;
      end else if (req_acc) begin
         if (col_ff == eff_w) begin
            col_in = '0;
            row_in = (row_ff == eff_h) ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   // slots taken by results in flight or queued
   always_comb begin
      cnt_in = cnt_ff;
      if (req_acc && tag0.result && !rsp_acc) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (rsp_acc && !(req_acc && tag0.result)) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         cnt_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         cnt_ff <= cnt_in;
      end
   end

   assign req_tready = (cnt_ff < COUNT_W'(OUT_DEPTH));

   dgrad_line_buf #(
      .MAX_WIDTH  (MAX_WIDTH),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_line_buf (
      .clock       (clock),
      .reset       (reset),
      .rd_en       (req_acc),
      .rd_addr     (col_ff),
      .px_i        (px),
      .tag_i       (tag0),
      .tag_o       (tag1),
      .px_o        (px1),
      .above_o     (above1),
      .two_above_o (two_above1)
   );

   dgrad_window #(
      .PIXEL_BITS (PIXEL_BITS)
   ) u_window (
      .clock       (clock),
      .reset       (reset),
      .tag_i       (tag1),
      .px_i        (px1),
      .above_i     (above1),
      .two_above_i (two_above1),
      .push_o      (push),
      .grad_x_o    (grad_x),
      .grad_y_o    (grad_y),
      .last_o      (last)
   );

   dgrad_out_fifo #(
      .OUT_DEPTH (OUT_DEPTH)
   ) u_out_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .grad_x_i   (grad_x),
      .grad_y_i   (grad_y),
      .last_i     (last),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

`include "depth_gradient_3x3_unit_assert.svh"

   `DGRAD_ASSERT_SAME(a_col_bound, 1'b1, col_ff <= eff_w, "column beyond padded row")
   `DGRAD_ASSERT_SAME(a_row_bound, 1'b1, row_ff <= eff_h, "row beyond padded frame")
   `DGRAD_ASSERT_SAME(a_pop_reserved, rsp_acc, cnt_ff != '0, "response without reserved slot")
   `DGRAD_ASSERT_NEXT(a_slot_taken, req_acc && tag0.result && !rsp_acc, cnt_ff == $past(cnt_ff) + 1'b1, "slot not reserved")

endmodule
